// ===== hdl/sliding_window_entropy_unit_assert.svh =====
// Assertion macros for the sliding window entropy unit.
`ifndef SLIDING_WINDOW_ENTROPY_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_ENTROPY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SWE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("swe assertion failed");
`define SWE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swe assertion failed");
`else
`define SWE_ASSERT(lbl, prop)
`define SWE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/swe_pkg.sv =====
// Shared types, constants and the n*log2(n) table of the sliding window entropy unit.
package swe_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int ALPHABET   = 32;
  localparam int SYM_W      = 5;
  localparam int LEN_W      = 7;
  localparam int WPTR_W     = $clog2(MAX_WINDOW);
  localparam int SUM_W      = 24;
  localparam int PLOG_W     = 22;
  localparam int ENT_W      = 16;
  localparam int DCNT_W     = $clog2(ENT_W + 1);
  localparam int AIDX_W     = $clog2(ALPHABET);

  localparam logic [LEN_W-1:0] SINCE_MAX   = '1;
  localparam logic [LEN_W-1:0] DEFAULT_LEN = LEN_W'(12);
  localparam logic [LEN_W-1:0] MIN_LEN     = LEN_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLD,
    ST_DEC,
    ST_NEW,
    ST_INC,
    ST_DIVGO,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              clr;
    logic              rd;
    logic              wr;
    logic [AIDX_W-1:0] addr;
    logic [LEN_W-1:0]  wdata;
  } cnt_req_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ENT_W-1:0] quot;
  } div_rsp_t;

  typedef logic [MAX_WINDOW:0][PLOG_W-1:0] plog_tab_t;

  function automatic logic [63:0] lg_q20(input int unsigned n);
    int unsigned k;
    logic [63:0] m;
    logic [63:0] frac;
    k = 0;
    for (int i = 1; i < 32; i++) begin
      if ((n >> i) != 0) k = i;
    end
    m = (64'(n) << 30) >> k;
    frac = '0;
    for (int i = 0; i < 20; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(k) << 20) | frac;
  endfunction

  function automatic plog_tab_t build_plog();
    plog_tab_t t;
    logic [63:0] v;
    t[0] = '0;
    for (int n = 1; n <= MAX_WINDOW; n++) begin
      v = (64'(n) * lg_q20(n) + 64'd64) >> 7;
      t[n] = v[PLOG_W-1:0];
    end
    return t;
  endfunction

  localparam plog_tab_t PLOG_TAB = build_plog();

endpackage

// ===== hdl/swe_cnt_tab.sv =====
// Per-symbol count table with registered read and valid bits cleared at once.
module swe_cnt_tab (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  swe_pkg::cnt_req_t        req_i,
  output logic [swe_pkg::LEN_W-1:0] rdata_o
);

  logic [swe_pkg::LEN_W-1:0]    mem [swe_pkg::ALPHABET];
  logic [swe_pkg::ALPHABET-1:0] vld_q;
  logic [swe_pkg::LEN_W-1:0]    rd_q;
  logic                         rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.clr) begin
      vld_q <= '0;
    end else if (req_i.wr) begin
      vld_q[req_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rd_q     <= mem[req_i.addr];
      rd_vld_q <= vld_q[req_i.addr];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== hdl/swe_div.sv =====
// Serial restoring divider, one quotient bit per cycle, saturating at full scale.
`include "sliding_window_entropy_unit_assert.svh"
module swe_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swe_pkg::div_req_t req_i,
  output swe_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [swe_pkg::DCNT_W-1:0]    cnt_q, cnt_d;
  logic [swe_pkg::LEN_W-1:0]     rem_q, rem_d;
  logic [swe_pkg::LEN_W-1:0]     dvs_q, dvs_d;
  logic [swe_pkg::ENT_W-1:0]     sh_q, sh_d;
  logic [swe_pkg::LEN_W:0]       trial;
  logic [swe_pkg::LEN_W:0]       diff;
  logic [swe_pkg::SUM_W-1:0]     limit;

  assign trial = {rem_q, sh_q[swe_pkg::ENT_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign limit = swe_pkg::SUM_W'({req_i.divisor, swe_pkg::ENT_W'(0)});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    sh_d   = sh_q;
    if (req_i.start) begin
      dvs_d = req_i.divisor;
      if (req_i.dividend >= limit) begin
        sh_d   = '1;
        done_d = 1'b1;
      end else begin
        rem_d  = req_i.dividend[swe_pkg::ENT_W +: swe_pkg::LEN_W];
        sh_d   = req_i.dividend[swe_pkg::ENT_W-1:0];
        cnt_d  = swe_pkg::DCNT_W'(swe_pkg::ENT_W);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[swe_pkg::LEN_W-1:0];
        sh_d  = {sh_q[swe_pkg::ENT_W-2:0], 1'b1};
      end else begin
        rem_d = trial[swe_pkg::LEN_W-1:0];
        sh_d  = {sh_q[swe_pkg::ENT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - swe_pkg::DCNT_W'(1);
      if (cnt_q == swe_pkg::DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    sh_q  <= sh_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q;

  `SWE_ASSERT(a_start_idle, req_i.start |-> !busy_q)
  `SWE_ASSERT_NEXT(a_done_pulse, done_q, !done_q)
  `SWE_ASSERT(a_rem_below_divisor, busy_q |-> rem_q < dvs_q)

endmodule

// ===== hdl/sliding_window_entropy_unit.sv =====
// Top level of the sliding window entropy unit: window store, sequencer and output register.
//
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | tdata: symbol; tuser: counted, valid_req
//  m_axis  | out | m_axis_tvalid/tready   | tdata: entropy Q3.13; tuser: masked
//  cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_data_i: window_length
//
// Most of a transaction is spent in the serial divider, 16 steps of one subtract and
// compare each; each count table access takes a state of the sequencer as well.
// Reset clears the count table valid bits at once; no clearing pass is needed.
// A finished result waits in the output register while the next transaction is taken.
// A configuration write empties the window and is taken only while idle.
`include "sliding_window_entropy_unit_assert.svh"
module sliding_window_entropy_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [4:0] symbol
  input  logic [1:0]                s_axis_tuser,   // [0] counted, [1] valid_req
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,   // [15:0] entropy
  output logic                      m_axis_tuser,   // [0] masked
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [swe_pkg::LEN_W-1:0] cfg_data_i
);

  localparam int ENTRY_W = swe_pkg::SYM_W + 1;

  swe_pkg::state_e state_q, state_d;

  logic [swe_pkg::LEN_W-1:0]  len_q, len_d;
  logic [swe_pkg::WPTR_W-1:0] wptr_q, wptr_d;
  logic [swe_pkg::LEN_W-1:0]  fill_q, fill_d;
  logic [swe_pkg::LEN_W-1:0]  since_q, since_d;
  logic [swe_pkg::SUM_W-1:0]  lsum_q, lsum_d;
  logic [swe_pkg::LEN_W-1:0]  ctot_q, ctot_d;
  logic [swe_pkg::SYM_W-1:0]  sym_q, sym_d;
  logic                       cnt_q, cnt_d;
  logic                       val_q, val_d;
  logic                       full_q, full_d;
  logic [swe_pkg::ENT_W-1:0]  res_q, res_d;
  logic                       m_valid_q, m_valid_d;
  logic [swe_pkg::ENT_W-1:0]  m_ent_q, m_ent_d;
  logic                       m_mask_q, m_mask_d;

  logic [ENTRY_W-1:0]         window_mem [swe_pkg::MAX_WINDOW];
  logic [ENTRY_W-1:0]         win_rd_q;
  logic                       win_we;
  logic                       win_re;
  logic [swe_pkg::WPTR_W-1:0] old_ptr;

  logic [swe_pkg::LEN_W-1:0]  w_eff;
  logic [swe_pkg::LEN_W-1:0]  c_rd;
  logic [swe_pkg::LEN_W-1:0]  c_inc;
  logic [swe_pkg::LEN_W-1:0]  c_dec;
  logic [swe_pkg::SUM_W-1:0]  top;
  logic                       in_acc;
  logic                       cfg_acc;

  swe_pkg::cnt_req_t cnt_req;
  swe_pkg::div_req_t div_req;
  swe_pkg::div_rsp_t div_rsp;

  assign w_eff = (len_q < swe_pkg::MIN_LEN) ? swe_pkg::MIN_LEN :
                 (len_q > swe_pkg::LEN_W'(swe_pkg::MAX_WINDOW)) ?
                 swe_pkg::LEN_W'(swe_pkg::MAX_WINDOW) : len_q;
  assign old_ptr = wptr_q - w_eff[swe_pkg::WPTR_W-1:0];
  assign c_inc   = c_rd + swe_pkg::LEN_W'(1);
  assign c_dec   = c_rd - swe_pkg::LEN_W'(1);
  assign top     = swe_pkg::SUM_W'(swe_pkg::PLOG_TAB[ctot_q]);

  assign cfg_ready_o   = (state_q == swe_pkg::ST_IDLE);
  assign s_axis_tready = (state_q == swe_pkg::ST_IDLE) && !cfg_valid_i;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;

  swe_cnt_tab u_cnt_tab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cnt_req),
    .rdata_o (c_rd)
  );

  swe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    wptr_d    = wptr_q;
    fill_d    = fill_q;
    since_d   = since_q;
    lsum_d    = lsum_q;
    ctot_d    = ctot_q;
    sym_d     = sym_q;
    cnt_d     = cnt_q;
    val_d     = val_q;
    full_d    = full_q;
    res_d     = res_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_ent_d   = m_ent_q;
    m_mask_d  = m_mask_q;
    win_we    = 1'b0;
    win_re    = 1'b0;
    cnt_req   = '0;
    div_req   = '0;
    case (state_q)
      swe_pkg::ST_IDLE: begin
        if (cfg_acc) begin
          len_d       = cfg_data_i;
          fill_d      = '0;
          lsum_d      = '0;
          ctot_d      = '0;
          since_d     = swe_pkg::SINCE_MAX;
          cnt_req.clr = 1'b1;
        end else if (in_acc) begin
          sym_d   = s_axis_tdata[swe_pkg::SYM_W-1:0];
          cnt_d   = s_axis_tuser[0];
          val_d   = s_axis_tuser[1];
          full_d  = fill_q >= w_eff;
          win_re  = 1'b1;
          state_d = swe_pkg::ST_OLD;
        end
      end
      swe_pkg::ST_OLD: begin
        fill_d = full_q ? w_eff : fill_q + swe_pkg::LEN_W'(1);
        if (full_q && win_rd_q[0]) begin
          cnt_req.rd   = 1'b1;
          cnt_req.addr = win_rd_q[ENTRY_W-1:1];
          state_d      = swe_pkg::ST_DEC;
        end else begin
          state_d = swe_pkg::ST_NEW;
        end
      end
      swe_pkg::ST_DEC: begin
        if (c_rd != '0) begin
          lsum_d        = lsum_q - swe_pkg::SUM_W'(swe_pkg::PLOG_TAB[c_rd])
                          + swe_pkg::SUM_W'(swe_pkg::PLOG_TAB[c_dec]);
          cnt_req.wr    = 1'b1;
          cnt_req.addr  = win_rd_q[ENTRY_W-1:1];
          cnt_req.wdata = c_dec;
          if (ctot_q != '0) begin
            ctot_d = ctot_q - swe_pkg::LEN_W'(1);
          end
        end
        state_d = swe_pkg::ST_NEW;
      end
      swe_pkg::ST_NEW: begin
        win_we = 1'b1;
        wptr_d = wptr_q + swe_pkg::WPTR_W'(1);
        if (!val_q) begin
          since_d = '0;
        end else if (since_q < swe_pkg::SINCE_MAX) begin
          since_d = since_q + swe_pkg::LEN_W'(1);
        end
        if (cnt_q) begin
          cnt_req.rd   = 1'b1;
          cnt_req.addr = sym_q;
          state_d      = swe_pkg::ST_INC;
        end else begin
          state_d = swe_pkg::ST_DIVGO;
        end
      end
      swe_pkg::ST_INC: begin
        if (c_rd < swe_pkg::LEN_W'(swe_pkg::MAX_WINDOW)) begin
          lsum_d        = lsum_q - swe_pkg::SUM_W'(swe_pkg::PLOG_TAB[c_rd])
                          + swe_pkg::SUM_W'(swe_pkg::PLOG_TAB[c_inc]);
          cnt_req.wr    = 1'b1;
          cnt_req.addr  = sym_q;
          cnt_req.wdata = c_inc;
          ctot_d        = ctot_q + swe_pkg::LEN_W'(1);
        end
        state_d = swe_pkg::ST_DIVGO;
      end
      swe_pkg::ST_DIVGO: begin
        if (ctot_q != '0 && top > lsum_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = top - lsum_q;
          div_req.divisor  = ctot_q;
          state_d          = swe_pkg::ST_DIV;
        end else begin
          res_d   = '0;
          state_d = swe_pkg::ST_OUT;
        end
      end
      swe_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          res_d   = div_rsp.quot;
          state_d = swe_pkg::ST_OUT;
        end
      end
      swe_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_ent_d   = res_q;
          m_mask_d  = (fill_q < w_eff) || (since_q < w_eff);
          state_d   = swe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= swe_pkg::ST_IDLE;
      len_q     <= swe_pkg::DEFAULT_LEN;
      wptr_q    <= '0;
      fill_q    <= '0;
      since_q   <= swe_pkg::SINCE_MAX;
      lsum_q    <= '0;
      ctot_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      wptr_q    <= wptr_d;
      fill_q    <= fill_d;
      since_q   <= since_d;
      lsum_q    <= lsum_d;
      ctot_q    <= ctot_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q    <= sym_d;
    cnt_q    <= cnt_d;
    val_q    <= val_d;
    full_q   <= full_d;
    res_q    <= res_d;
    m_ent_q  <= m_ent_d;
    m_mask_q <= m_mask_d;
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      window_mem[wptr_q] <= {sym_q, cnt_q};
    end
    if (win_re) begin
      win_rd_q <= window_mem[old_ptr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_ent_q;
  assign m_axis_tuser  = m_mask_q;

  `SWE_ASSERT(a_fill_in_window, fill_q <= w_eff)
  `SWE_ASSERT(a_total_le_fill, ctot_q <= fill_q)
  `SWE_ASSERT_NEXT(a_accept_starts, in_acc, state_q == swe_pkg::ST_OLD)

endmodule

// ===== tb/sv/sliding_window_entropy_unit_tb.sv =====
// Self-checking stream testbench for the sliding window entropy unit.
`timescale 1ns / 1ps
module sliding_window_entropy_unit_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam longint LIMIT_NS = 64'd6_000_000;

  typedef struct packed {
    logic [swe_pkg::SYM_W-1:0] symbol;
    logic                      counted;
    logic                      valid_req;
  } residue_t;

  typedef struct packed {
    logic [swe_pkg::ENT_W-1:0] entropy;
    logic                      masked;
  } window_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata = '0;   // [4:0] symbol
  logic [1:0]                   s_axis_tuser = '0;   // [0] counted, [1] valid_req
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [15:0]                  m_axis_tdata;        // [15:0] entropy
  logic                         m_axis_tuser;        // [0] masked
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [swe_pkg::LEN_W-1:0]    cfg_data_i = '0;

  residue_t       pending_q[$];
  window_result_t entropy_q[$];
  logic           in_taken = 1'b0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  logic           hold_req_tgl = 1'b0;
  logic           hold_ack_tgl = 1'b0;
  int             hold_left = 0;
  int             err_count = 0;
  int             residues_sent = 0;
  int             masked_seen = 0;
  int             open_seen = 0;
  int             settings_used = 1;

  // window predictor state
  int unsigned               nlog_q13[0:swe_pkg::MAX_WINDOW];
  logic [swe_pkg::LEN_W-1:0] win_len;
  logic [swe_pkg::SYM_W-1:0] hist_sym[swe_pkg::MAX_WINDOW];
  logic                      hist_cnt[swe_pkg::MAX_WINDOW];
  int unsigned               hist_ptr;
  int unsigned               sym_count[swe_pkg::ALPHABET];
  int unsigned               plog_sum;
  int unsigned               count_total;
  int unsigned               fill;
  int unsigned               since_bad;

  sliding_window_entropy_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint unsigned log2_q20(int unsigned n);
    int unsigned ip;
    longint unsigned mant;
    longint unsigned fr;
    ip = 0;
    while ((n >> (ip + 1)) != 0) ip++;
    mant = (64'(n) << 30) >> ip;
    fr = 0;
    repeat (20) begin
      mant = (mant * mant) >> 30;
      fr = fr << 1;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        fr = fr | 64'd1;
      end
    end
    return (64'(ip) << 20) | fr;
  endfunction

  function automatic void build_nlog();
    longint unsigned v;
    nlog_q13[0] = 0;
    for (int n = 1; n <= swe_pkg::MAX_WINDOW; n++) begin
      v = (64'(n) * log2_q20(n) + 64'd64) >> 7;
      nlog_q13[n] = v[31:0];
    end
  endfunction

  function automatic void empty_window();
    foreach (sym_count[i]) sym_count[i] = 0;
    plog_sum = 0;
    count_total = 0;
    fill = 0;
    since_bad = swe_pkg::SINCE_MAX;
  endfunction

  function automatic int unsigned span();
    if (win_len < swe_pkg::MIN_LEN) return swe_pkg::MIN_LEN;
    if (win_len > swe_pkg::MAX_WINDOW) return swe_pkg::MAX_WINDOW;
    return win_len;
  endfunction

  function automatic window_result_t slide_window(residue_t r);
    window_result_t res;
    int unsigned w;
    int unsigned old;
    int unsigned c;
    int unsigned top;
    int unsigned ent;
    w = span();
    ent = 0;
    if (fill >= w) begin
      old = (hist_ptr + swe_pkg::MAX_WINDOW - w) % swe_pkg::MAX_WINDOW;
      if (hist_cnt[old] && sym_count[hist_sym[old]] > 0) begin
        c = sym_count[hist_sym[old]];
        plog_sum = plog_sum - nlog_q13[c] + nlog_q13[c-1];
        sym_count[hist_sym[old]] = c - 1;
        if (count_total > 0) count_total--;
      end
      fill = w;
    end else begin
      fill++;
    end
    hist_sym[hist_ptr] = r.symbol;
    hist_cnt[hist_ptr] = r.counted;
    hist_ptr = (hist_ptr + 1) % swe_pkg::MAX_WINDOW;
    if (r.counted) begin
      c = sym_count[r.symbol];
      if (c < swe_pkg::MAX_WINDOW) begin
        plog_sum = plog_sum - nlog_q13[c] + nlog_q13[c+1];
        sym_count[r.symbol] = c + 1;
        count_total++;
      end
    end
    if (!r.valid_req) since_bad = 0;
    else if (since_bad < swe_pkg::SINCE_MAX) since_bad++;
    if (count_total > 0 && count_total <= swe_pkg::MAX_WINDOW) begin
      top = nlog_q13[count_total];
      if (top > plog_sum) begin
        ent = (top - plog_sum) / count_total;
        if (ent > 65535) ent = 65535;
      end
    end
    res.entropy = ent[swe_pkg::ENT_W-1:0];
    res.masked = (fill < w) || (since_bad < w);
    return res;
  endfunction

  function automatic residue_t random_residue();
    residue_t r;
    int pick;
    pick = $urandom_range(99);
    r.symbol = (pick < 50) ? swe_pkg::SYM_W'($urandom_range(3)) :
               swe_pkg::SYM_W'($urandom_range(swe_pkg::ALPHABET - 1));
    r.counted = ($urandom_range(99) >= 10);
    r.valid_req = ($urandom_range(99) >= 4);
    return r;
  endfunction

  // driver: hold the offer until taken, then advance
  always @(negedge clk_i) begin
    residue_t r;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        r = pending_q.pop_front();
        s_axis_tdata <= {3'b000, r.symbol};
        s_axis_tuser <= {r.valid_req, r.counted};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req_tgl != hold_ack_tgl) begin
      hold_ack_tgl <= hold_req_tgl;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: check each result transaction, then predict from each input transaction
  always @(posedge clk_i) begin
    window_result_t want;
    residue_t r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (entropy_q.size() == 0) begin
        $error("result with no pending residue: entropy %0d masked %0d",
               m_axis_tdata, m_axis_tuser);
        err_count++;
      end else begin
        want = entropy_q.pop_front();
        if (m_axis_tdata !== want.entropy) begin
          $error("entropy: expected %0d, got %0d", want.entropy, m_axis_tdata);
          err_count++;
        end
        if (m_axis_tuser !== want.masked) begin
          $error("masked: expected %0d, got %0d", want.masked, m_axis_tuser);
          err_count++;
        end
        if (want.masked) masked_seen++;
        else open_seen++;
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      r.symbol = s_axis_tdata[swe_pkg::SYM_W-1:0];
      r.counted = s_axis_tuser[0];
      r.valid_req = s_axis_tuser[1];
      entropy_q.push_back(slide_window(r));
      residues_sent++;
    end
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  task automatic drain();
    wait (pending_q.size() == 0 && !s_axis_tvalid);
    wait (entropy_q.size() == 0);
  endtask

  task automatic write_window_length(input logic [swe_pkg::LEN_W-1:0] len);
    @(negedge clk_i);
    cfg_data_i <= len;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    win_len = len;
    empty_window();
    settings_used++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [swe_pkg::LEN_W-1:0] len, input int n, input int run_len,
                           input int send_pct, input int recv_pct, input bit hold);
    residue_t r;
    write_window_length(len);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (hold) hold_req_tgl = ~hold_req_tgl;
    r.symbol = swe_pkg::SYM_W'($urandom_range(swe_pkg::ALPHABET - 1));
    r.counted = 1'b1;
    r.valid_req = 1'b1;
    repeat (run_len) pending_q.push_back(r);
    repeat (n - run_len) pending_q.push_back(random_residue());
    drain();
  endtask

  initial begin
    residue_t r;
    build_nlog();
    win_len = swe_pkg::DEFAULT_LEN;
    hist_ptr = 0;
    foreach (hist_sym[i]) begin
      hist_sym[i] = '0;
      hist_cnt[i] = 1'b0;
    end
    empty_window();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty count, field extremes, invalid position, full window with eviction
    pending_q.push_back('{symbol: 5'd0, counted: 1'b0, valid_req: 1'b1});
    pending_q.push_back('{symbol: 5'd31, counted: 1'b1, valid_req: 1'b1});
    pending_q.push_back('{symbol: 5'd0, counted: 1'b1, valid_req: 1'b1});
    pending_q.push_back('{symbol: 5'd31, counted: 1'b1, valid_req: 1'b0});
    for (int i = 1; i <= 12; i++) begin
      r.symbol = swe_pkg::SYM_W'(i);
      r.counted = 1'b1;
      r.valid_req = 1'b1;
      pending_q.push_back(r);
    end
    repeat (8) pending_q.push_back('{symbol: 5'd5, counted: 1'b1, valid_req: 1'b1});
    drain();

    run_phase(7'd0,   40,  0, 50,  0, 1'b0);
    run_phase(7'd127, 140, 0,  0, 50, 1'b1);
    run_phase(7'd1,   30,  0, 10, 10, 1'b0);
    run_phase(7'd64,  90, 70,  0,  0, 1'b0);
    run_phase(swe_pkg::LEN_W'($urandom_range(20, 2)), 60, 0, 50, 0, 1'b0);
    run_phase(swe_pkg::LEN_W'($urandom_range(127)), 40, 0, 10, 10, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d residues under %0d window settings, including a long output stall",
             residues_sent, settings_used);
    $display("results checked: %0d masked, %0d unmasked", masked_seen, open_seen);
    if (err_count == 0 && entropy_q.size() == 0) begin
      $display("sliding_window_entropy_unit: match");
    end else begin
      $display("sliding_window_entropy_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", entropy_q.size());
    $display("sliding_window_entropy_unit: mismatch");
    $finish;
  end

endmodule

// ===== sliding_window_entropy_unit.f =====
+incdir+hdl
hdl/swe_pkg.sv
hdl/swe_cnt_tab.sv
hdl/swe_div.sv
hdl/sliding_window_entropy_unit.sv
tb/sv/sliding_window_entropy_unit_tb.sv
